@@ sv/assert_macros.svh @@
// shared assertion helpers, clocked on i_clk and quiet while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// holds in the same cycle
`define ACPU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// cause in this cycle, effect in the next
`define ACPU_ASSERT_NEXT(label, cause, effect, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cause) |=> (effect)) else $error(msg);

`endif

@@ sv/acpu_pkg.sv @@
package acpu_pkg;

    localparam int unsigned DEF_MEMORY_WORDS = 4096;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;
    localparam logic [1:0] MODE_EXEC  = 2'd3;

    localparam logic [2:0] OP_AND = 3'd0;
    localparam logic [2:0] OP_TAD = 3'd1;
    localparam logic [2:0] OP_ISZ = 3'd2;
    localparam logic [2:0] OP_DCA = 3'd3;
    localparam logic [2:0] OP_JMS = 3'd4;
    localparam logic [2:0] OP_JMP = 3'd5;
    localparam logic [2:0] OP_IOT = 3'd6;
    localparam logic [2:0] OP_OPR = 3'd7;

    localparam logic [5:0] DEV_KEYBOARD = 6'd3;
    localparam logic [5:0] DEV_PRINTER  = 6'd4;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_DECODE,
        S_INDIR,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic capture;
        logic clr_step;
        logic rd_pc;
        logic decode;
        logic indir;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic       halted;
        logic [2:0] opcode;
        logic       indirect;
        logic       out_free;
        logic       clr_last;
    } t_sts;

    // address folded into the memory range by five compare and subtract steps
    function automatic logic [11:0] mod_words(input logic [11:0] a,
                                              input int unsigned words);
        logic [16:0] r;
        logic [16:0] m;
        r = {5'd0, a};
        m = 17'(words);
        for (int k = 4; k >= 0; k--) begin
            if (r >= (m << k)) begin
                r = r - (m << k);
            end
        end
        return r[11:0];
    endfunction

    // microcoded group 1, result is {link, acc}
    function automatic logic [12:0] group_one(input logic [11:0] w,
                                              input logic [11:0] acc,
                                              input logic link);
        logic [11:0] a;
        logic        l;
        logic [12:0] s;
        a = acc;
        l = link;
        if (w[7]) a = '0;
        if (w[6]) l = 1'b0;
        if (w[5]) a = ~a;
        if (w[4]) l = ~l;
        if (w[0]) begin
            s = {1'b0, a} + 13'd1;
            a = s[11:0];
            if (s[12]) l = ~l;
        end
        if (w[3]) begin
            s = {a[0], l, a[11:1]};
            if (w[1]) s = {s[0], s[12:1]};
            l = s[12];
            a = s[11:0];
        end
        if (w[2]) begin
            s = {a[11], a[10:0], l};
            if (w[1]) s = {s[11], s[10:0], s[12]};
            l = s[12];
            a = s[11:0];
        end
        if (w[1] && !w[3] && !w[2]) a = {a[5:0], a[11:6]};
        return {l, a};
    endfunction

endpackage

@@ sv/acpu_in_if.sv @@
interface acpu_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [11:0] address;
    logic [11:0] load_data;
    logic [11:0] keyboard_value;

    modport source (output valid, mode, address, load_data, keyboard_value, input ready);
    modport sink (input valid, mode, address, load_data, keyboard_value, output ready);
endinterface

@@ sv/acpu_out_if.sv @@
interface acpu_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] program_counter;
    logic [11:0] accumulator;
    logic        link_bit;
    logic        is_halted;
    logic        char_valid;
    logic [7:0]  char_out;
    logic        bad_device;
    logic [11:0] executed_word;
    logic [47:0] elapsed_cycles;

    modport source (output valid, program_counter, accumulator, link_bit, is_halted,
                    char_valid, char_out, bad_device, executed_word, elapsed_cycles,
                    input ready);
    modport sink (input valid, program_counter, accumulator, link_bit, is_halted,
                  char_valid, char_out, bad_device, executed_word, elapsed_cycles,
                  output ready);
endinterface

@@ sv/accumulator_cpu_instruction_step.sv @@
// Twelve-bit accumulator machine, one transaction in, one result out.
// i_in carries mode, address, load_data and keyboard_value; o_out returns the
// machine state after the transaction (pc, accumulator, link, halt, printer byte,
// bad device flag, executed word and running cycle count).
// i_cfg_we with i_cfg_wdata writes the switch register, used by OSR.
// Load, start or execute while halted go from acceptance straight to the result;
// execute passes fetch, decode, a pointer step for an indirect operand, then exec;
// clear memory sweeps every word once before the result. The single memory port
// sets the steps: fetch, pointer read, operand read and write-back each own a state.
// One transaction is worked at a time; i_in.ready is high while the controller
// is idle, and a new transaction is taken while the previous result still waits.
// If o_out.ready stays low, the result is held and the next transaction stalls
// just before its result would be registered.
// Reset clears pc, accumulator, link, cycle count and switch register, leaves the
// machine halted and sweeps every memory word once before i_in.ready first rises.
module accumulator_cpu_instruction_step
    import acpu_pkg::*;
#(
    parameter int unsigned MEMORY_WORDS = DEF_MEMORY_WORDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [11:0] i_cfg_wdata,
    acpu_in_if.sink     i_in,
    acpu_out_if.source  o_out
);

    t_cmd w_cmd;
    t_sts w_sts;

    acpu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_mode     (i_in.mode),
        .i_sts      (w_sts),
        .o_in_ready (i_in.ready),
        .o_cmd      (w_cmd)
    );

    acpu_dpath #(
        .MEMORY_WORDS (MEMORY_WORDS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_mode           (i_in.mode),
        .i_address        (i_in.address),
        .i_load_data      (i_in.load_data),
        .i_keyboard_value (i_in.keyboard_value),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_out            (o_out)
    );

endmodule

@@ sv/acpu_ctrl.sv @@
`include "assert_macros.svh"

module acpu_ctrl
    import acpu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_mode,
    input  t_sts       i_sts,
    output logic       o_in_ready,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_from_item;
    logic   n_from_item;
    logic   w_accept;

    assign w_accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_from_item <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_from_item <= n_from_item;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_from_item = r_from_item;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) n_state = r_from_item ? S_EXEC : S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_from_item = 1'b0;
                    case (i_mode)
                        MODE_CLEAR: begin
                            n_state     = S_CLEAR;
                            n_from_item = 1'b1;
                        end
                        MODE_EXEC: n_state = i_sts.halted ? S_EXEC : S_FETCH;
                        default:   n_state = S_EXEC;
                    endcase
                end
            end
            S_FETCH: n_state = S_DECODE;
            S_DECODE: begin
                // indirect pointer read only for memory reference opcodes
                if (i_sts.indirect && (i_sts.opcode inside {[OP_AND:OP_JMP]})) begin
                    n_state = S_INDIR;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_INDIR: n_state = S_EXEC;
            S_EXEC: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready       = (r_state == S_IDLE);
        o_cmd.capture    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.clr_step   = (r_state == S_CLEAR);
        o_cmd.rd_pc      = (r_state == S_FETCH);
        o_cmd.decode     = (r_state == S_DECODE);
        o_cmd.indir      = (r_state == S_INDIR);
        o_cmd.exec       = (r_state == S_EXEC) && i_sts.out_free;
    end

    `ACPU_ASSERT(a_exec_needs_room, !o_cmd.exec || i_sts.out_free, "exec with output full")
    `ACPU_ASSERT_NEXT(a_clear_holds, (r_state == S_CLEAR) && !i_sts.clr_last, r_state == S_CLEAR, "clear sweep cut short")
    `ACPU_ASSERT_NEXT(a_accept_leaves_idle, w_accept, r_state != S_IDLE, "stayed idle after transaction")

endmodule

@@ sv/acpu_dpath.sv @@
`include "assert_macros.svh"

module acpu_dpath
    import acpu_pkg::*;
#(
    parameter int unsigned MEMORY_WORDS = DEF_MEMORY_WORDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [11:0] i_cfg_wdata,
    input  logic [1:0]  i_mode,
    input  logic [11:0] i_address,
    input  logic [11:0] i_load_data,
    input  logic [11:0] i_keyboard_value,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    acpu_out_if.source  o_out
);

    localparam int unsigned AW = $clog2(MEMORY_WORDS);

    logic [12:0]   mem [MEMORY_WORDS];
    logic [12:0]   r_rdata;

    logic [1:0]    r_mode;
    logic [11:0]   r_addr;
    logic [11:0]   r_ldata;
    logic [11:0]   r_key;
    logic [11:0]   r_word;
    logic [11:0]   r_ea;
    logic [11:0]   r_sw;
    logic [AW-1:0] r_clr_idx;

    logic [11:0]   r_pc;
    logic [11:0]   r_acc;
    logic          r_link;
    logic          r_halt;
    logic [47:0]   r_cycles;

    logic          r_out_valid;
    logic [11:0]   r_o_pc;
    logic [11:0]   r_o_acc;
    logic          r_o_link;
    logic          r_o_halt;
    logic          r_o_cvalid;
    logic [7:0]    r_o_cout;
    logic          r_o_bad;
    logic [11:0]   r_o_word;
    logic [47:0]   r_o_cycles;

    logic [11:0]   n_pc;
    logic [11:0]   n_acc;
    logic          n_link;
    logic          n_halt;
    logic [47:0]   n_cycles;
    logic          w_cvalid;
    logic [7:0]    w_cout;
    logic          w_bad;

    logic [11:0]   w_rd;
    logic [11:0]   w_ea_dir;
    logic          w_we;
    logic          w_re;
    logic [11:0]   w_maddr;
    logic [12:0]   w_wdata;
    logic [11:0]   w_mod;
    logic [AW-1:0] w_idx;
    logic          w_clr_last;
    logic          w_running;
    logic [2:0]    w_op;
    logic [12:0]   w_sum;
    logic [11:0]   w_inc;
    logic [12:0]   w_g1;
    logic          w_skip;
    logic [11:0]   w_g2_acc;
    logic [1:0]    w_cost;
    logic [5:0]    w_dev;

    // unwritten words read as zero
    assign w_rd      = r_rdata[12] ? r_rdata[11:0] : 12'd0;
    assign w_ea_dir  = {(w_rd[7] ? r_pc[11:7] : 5'd0), w_rd[6:0]};
    assign w_clr_last = (r_clr_idx == AW'(MEMORY_WORDS - 1));
    assign w_running = (r_mode == MODE_EXEC) && !r_halt;
    assign w_op      = r_word[11:9];

    always_comb begin
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_maddr = r_pc;
        w_wdata = {1'b1, r_acc};
        if (i_cmd.clr_step) begin
            w_we    = 1'b1;
            w_maddr = 12'(r_clr_idx);
            w_wdata = '0;
        end else if (i_cmd.rd_pc) begin
            w_re    = 1'b1;
            w_maddr = r_pc;
        end else if (i_cmd.decode) begin
            w_maddr = w_ea_dir;
            w_re    = (w_rd[8] && (w_rd[11:9] inside {[OP_AND:OP_JMP]}))
                   || (w_rd[11:9] inside {[OP_AND:OP_ISZ]});
        end else if (i_cmd.indir) begin
            w_maddr = w_rd;
            w_re    = (w_op inside {[OP_AND:OP_ISZ]});
        end else if (i_cmd.exec) begin
            if (r_mode == MODE_LOAD) begin
                w_we    = 1'b1;
                w_maddr = r_addr;
                w_wdata = {1'b1, r_ldata};
            end else if (w_running) begin
                w_maddr = r_ea;
                case (w_op)
                    OP_ISZ: begin
                        w_we    = 1'b1;
                        w_wdata = {1'b1, w_inc};
                    end
                    OP_DCA: begin
                        w_we    = 1'b1;
                        w_wdata = {1'b1, r_acc};
                    end
                    OP_JMS: begin
                        w_we    = 1'b1;
                        w_wdata = {1'b1, r_pc};
                    end
                    default: w_we = 1'b0;
                endcase
            end
        end
    end

    assign w_mod = mod_words(w_maddr, MEMORY_WORDS);
    assign w_idx = w_mod[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_idx] <= w_wdata;
        if (w_re) r_rdata <= mem[w_idx];
    end

    always_comb begin
        w_sum    = {1'b0, r_acc} + {1'b0, w_rd};
        w_inc    = w_rd + 12'd1;
        w_g1     = group_one(r_word, r_acc, r_link);
        w_dev    = r_word[8:3];
        w_skip   = (r_word[6] && r_acc[11]) || (r_word[5] && (r_acc == 12'd0))
                || (r_word[4] && r_link);
        if (r_word[3]) w_skip = !w_skip;
        w_g2_acc = r_word[7] ? 12'd0 : r_acc;
        if (r_word[2]) w_g2_acc = w_g2_acc | r_sw;
        w_cost   = (w_op inside {[OP_AND:OP_JMS]}) ? 2'd2 : 2'd1;
        if (r_word[8] && (w_op inside {[OP_AND:OP_JMP]})) w_cost = w_cost + 2'd1;

        n_pc     = r_pc;
        n_acc    = r_acc;
        n_link   = r_link;
        n_halt   = r_halt;
        n_cycles = r_cycles;
        w_cvalid = 1'b0;
        w_cout   = 8'd0;
        w_bad    = 1'b0;
        case (r_mode)
            MODE_START: begin
                n_cycles = '0;
                n_halt   = 1'b0;
                n_pc     = r_addr;
            end
            MODE_EXEC: begin
                if (!r_halt) begin
                    n_cycles = r_cycles + 48'(w_cost);
                    case (w_op)
                        OP_AND: n_acc = r_acc & w_rd;
                        OP_TAD: begin
                            n_acc  = w_sum[11:0];
                            n_link = r_link ^ w_sum[12];
                        end
                        OP_ISZ: begin
                            if (w_inc == 12'd0) n_pc = r_pc + 12'd1;
                        end
                        OP_DCA: n_acc = 12'd0;
                        OP_JMS: n_pc = r_ea + 12'd1;
                        OP_JMP: n_pc = r_ea;
                        OP_IOT: begin
                            if (w_dev == DEV_KEYBOARD) begin
                                n_acc = r_key;
                            end else if (w_dev == DEV_PRINTER) begin
                                w_cvalid = 1'b1;
                                w_cout   = r_acc[7:0];
                            end else begin
                                w_bad  = 1'b1;
                                n_halt = 1'b1;
                            end
                        end
                        default: begin
                            if (r_word[8]) begin
                                if (w_skip) n_pc = r_pc + 12'd1;
                                n_acc = w_g2_acc;
                                if (r_word[1]) n_halt = 1'b1;
                            end else begin
                                n_acc  = w_g1[11:0];
                                n_link = w_g1[12];
                            end
                        end
                    endcase
                end
            end
            default: n_pc = r_pc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= '0;
            r_acc       <= '0;
            r_link      <= 1'b0;
            r_halt      <= 1'b1;
            r_cycles    <= '0;
            r_sw        <= '0;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_sw <= i_cfg_wdata;
            if (i_cmd.clr_step) r_clr_idx <= w_clr_last ? '0 : r_clr_idx + AW'(1);
            if (i_cmd.decode) begin
                r_pc <= r_pc + 12'd1;
            end else if (i_cmd.exec) begin
                r_pc <= n_pc;
            end
            if (i_cmd.exec) begin
                r_acc    <= n_acc;
                r_link   <= n_link;
                r_halt   <= n_halt;
                r_cycles <= n_cycles;
            end
            if (i_cmd.exec) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= i_mode;
            r_addr  <= i_address;
            r_ldata <= i_load_data;
            r_key   <= i_keyboard_value;
        end
        if (i_cmd.decode) begin
            r_word <= w_rd;
            r_ea   <= w_ea_dir;
        end else if (i_cmd.indir) begin
            r_ea <= w_rd;
        end
        if (i_cmd.exec) begin
            r_o_pc     <= n_pc;
            r_o_acc    <= n_acc;
            r_o_link   <= n_link;
            r_o_halt   <= n_halt;
            r_o_cvalid <= w_cvalid;
            r_o_cout   <= w_cout;
            r_o_bad    <= w_bad;
            r_o_word   <= w_running ? r_word : 12'd0;
            r_o_cycles <= n_cycles;
        end
    end

    always_comb begin
        o_sts.halted   = r_halt;
        o_sts.opcode   = w_rd[11:9];
        o_sts.indirect = w_rd[8];
        o_sts.out_free = !r_out_valid || o_out.ready;
        o_sts.clr_last = w_clr_last;
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.program_counter = r_o_pc;
    assign o_out.accumulator     = r_o_acc;
    assign o_out.link_bit        = r_o_link;
    assign o_out.is_halted       = r_o_halt;
    assign o_out.char_valid      = r_o_cvalid;
    assign o_out.char_out        = r_o_cout;
    assign o_out.bad_device      = r_o_bad;
    assign o_out.executed_word   = r_o_word;
    assign o_out.elapsed_cycles  = r_o_cycles;

    `ACPU_ASSERT(a_one_port, $onehot0({w_we, w_re}), "memory read and write together")
    `ACPU_ASSERT_NEXT(a_exec_fills_out, i_cmd.exec, r_out_valid, "result not registered")
    `ACPU_ASSERT_NEXT(a_halted_no_count, i_cmd.exec && (r_mode == MODE_EXEC) && r_halt, $stable(r_cycles) && $stable(r_pc), "halted machine advanced")

endmodule
